// ----- design/lmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_pkg
// types, register map and arithmetic helpers shared by the lumel combiner
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int unsigned NUM_LIGHT_SLOTS = 4;
	localparam int unsigned CHAN_W          = 8;
	localparam int unsigned CODE_W          = 10;
	localparam int unsigned LIGHT_W         = 3 * CODE_W;
	localparam int unsigned COUNT_W         = 3;
	localparam int unsigned TERM_W          = CODE_W;
	localparam int unsigned PROD_W          = CODE_W + CHAN_W;
	localparam int unsigned ADDR_W          = 5;
	localparam int unsigned DATA_W          = 32;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(128);
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

	// register index, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_AMBIENT_RED   = 3'd0,
		REG_AMBIENT_GREEN = 3'd1,
		REG_AMBIENT_BLUE  = 3'd2,
		REG_LIGHT_COUNT   = 3'd3,
		REG_LIGHT_COLOR_0 = 3'd4,
		REG_LIGHT_COLOR_1 = 3'd5,
		REG_LIGHT_COLOR_2 = 3'd6,
		REG_LIGHT_COLOR_3 = 3'd7
	} lmc_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]                         ambient_red;
		logic [CHAN_W-1:0]                         ambient_green;
		logic [CHAN_W-1:0]                         ambient_blue;
		logic [COUNT_W-1:0]                        light_count;
		logic [NUM_LIGHT_SLOTS-1:0][LIGHT_W-1:0]   light_color;
	} lmc_cfg_t;

	// rounded u2.8 code times shadow byte, half up
	function automatic logic [TERM_W-1:0] light_term(
		input logic [CODE_W-1:0] code,
		input logic [CHAN_W-1:0] shade
	);
		logic [PROD_W-1:0] prod;
		prod = (PROD_W'(code) * PROD_W'(shade)) + ROUND_HALF;
		return prod[PROD_W-1:CHAN_W];
	endfunction

	// saturating add of a channel value and a term
	function automatic logic [CHAN_W-1:0] sat_add(
		input logic [CHAN_W-1:0] a,
		input logic [TERM_W-1:0] b
	);
		logic [TERM_W:0] sum;
		sum = (TERM_W+1)'(a) + (TERM_W+1)'(b);
		return (sum > (TERM_W+1)'(CHAN_MAX)) ? CHAN_MAX : sum[CHAN_W-1:0];
	endfunction

endpackage

// ----- design/lmc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_cfg_regs
// apb register file holding ambient color, light count and light colors
// ----------------------------------------------------------------------------
module lmc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lmc_pkg::ADDR_W-1:0]  paddr,
	input  logic [lmc_pkg::DATA_W-1:0]  pwdata,
	output logic [lmc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output lmc_pkg::lmc_cfg_t           cfg
);

	lmc_pkg::lmc_cfg_t cfg_q;
	lmc_pkg::lmc_reg_t reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = lmc_pkg::lmc_reg_t'(paddr[lmc_pkg::ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				lmc_pkg::REG_AMBIENT_RED: begin
					cfg_q.ambient_red <= pwdata[lmc_pkg::CHAN_W-1:0];
				end
				lmc_pkg::REG_AMBIENT_GREEN: begin
					cfg_q.ambient_green <= pwdata[lmc_pkg::CHAN_W-1:0];
				end
				lmc_pkg::REG_AMBIENT_BLUE: begin
					cfg_q.ambient_blue <= pwdata[lmc_pkg::CHAN_W-1:0];
				end
				lmc_pkg::REG_LIGHT_COUNT: begin
					cfg_q.light_count <= pwdata[lmc_pkg::COUNT_W-1:0];
				end
				lmc_pkg::REG_LIGHT_COLOR_0: begin
					cfg_q.light_color[0] <= pwdata[lmc_pkg::LIGHT_W-1:0];
				end
				lmc_pkg::REG_LIGHT_COLOR_1: begin
					cfg_q.light_color[1] <= pwdata[lmc_pkg::LIGHT_W-1:0];
				end
				lmc_pkg::REG_LIGHT_COLOR_2: begin
					cfg_q.light_color[2] <= pwdata[lmc_pkg::LIGHT_W-1:0];
				end
				lmc_pkg::REG_LIGHT_COLOR_3: begin
					cfg_q.light_color[3] <= pwdata[lmc_pkg::LIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			lmc_pkg::REG_AMBIENT_RED:   prdata = lmc_pkg::DATA_W'(cfg_q.ambient_red);
			lmc_pkg::REG_AMBIENT_GREEN: prdata = lmc_pkg::DATA_W'(cfg_q.ambient_green);
			lmc_pkg::REG_AMBIENT_BLUE:  prdata = lmc_pkg::DATA_W'(cfg_q.ambient_blue);
			lmc_pkg::REG_LIGHT_COUNT:   prdata = lmc_pkg::DATA_W'(cfg_q.light_count);
			lmc_pkg::REG_LIGHT_COLOR_0: prdata = lmc_pkg::DATA_W'(cfg_q.light_color[0]);
			lmc_pkg::REG_LIGHT_COLOR_1: prdata = lmc_pkg::DATA_W'(cfg_q.light_color[1]);
			lmc_pkg::REG_LIGHT_COLOR_2: prdata = lmc_pkg::DATA_W'(cfg_q.light_color[2]);
			lmc_pkg::REG_LIGHT_COLOR_3: prdata = lmc_pkg::DATA_W'(cfg_q.light_color[3]);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- design/lmc_shade_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_shade_calc
// static color plus ambient plus per-light rounded color times shadow, saturating per channel
// ----------------------------------------------------------------------------
module lmc_shade_calc #(
	parameter int unsigned MAX_LIGHTS = 4
) (
	input  lmc_pkg::lmc_cfg_t                                cfg,
	input  logic [lmc_pkg::CHAN_W-1:0]                       static_red,
	input  logic [lmc_pkg::CHAN_W-1:0]                       static_green,
	input  logic [lmc_pkg::CHAN_W-1:0]                       static_blue,
	input  logic [MAX_LIGHTS-1:0][lmc_pkg::CHAN_W-1:0]       shadow,
	output logic [lmc_pkg::CHAN_W-1:0]                       lit_red,
	output logic [lmc_pkg::CHAN_W-1:0]                       lit_green,
	output logic [lmc_pkg::CHAN_W-1:0]                       lit_blue
);

	localparam int unsigned CW = lmc_pkg::CODE_W;

	logic [lmc_pkg::COUNT_W-1:0]               count_eff;
	logic [MAX_LIGHTS-1:0]                     light_en;
	logic [MAX_LIGHTS-1:0][lmc_pkg::TERM_W-1:0] term_r;
	logic [MAX_LIGHTS-1:0][lmc_pkg::TERM_W-1:0] term_g;
	logic [MAX_LIGHTS-1:0][lmc_pkg::TERM_W-1:0] term_b;
	logic [MAX_LIGHTS:0][lmc_pkg::CHAN_W-1:0]   acc_r;
	logic [MAX_LIGHTS:0][lmc_pkg::CHAN_W-1:0]   acc_g;
	logic [MAX_LIGHTS:0][lmc_pkg::CHAN_W-1:0]   acc_b;

	// counts above the lane count clamp to it
	assign count_eff = (cfg.light_count > lmc_pkg::COUNT_W'(MAX_LIGHTS)) ?
		lmc_pkg::COUNT_W'(MAX_LIGHTS) : cfg.light_count;

	assign acc_r[0] = lmc_pkg::sat_add(static_red,
		lmc_pkg::TERM_W'(cfg.ambient_red));
	assign acc_g[0] = lmc_pkg::sat_add(static_green,
		lmc_pkg::TERM_W'(cfg.ambient_green));
	assign acc_b[0] = lmc_pkg::sat_add(static_blue,
		lmc_pkg::TERM_W'(cfg.ambient_blue));

	for (genvar i = 0; i < MAX_LIGHTS; i++) begin : g_light
		assign light_en[i] = (lmc_pkg::COUNT_W'(i) < count_eff);

		// disabled lights contribute nothing
		assign term_r[i] = light_en[i] ?
			lmc_pkg::light_term(cfg.light_color[i][3*CW-1:2*CW], shadow[i]) : '0;
		assign term_g[i] = light_en[i] ?
			lmc_pkg::light_term(cfg.light_color[i][2*CW-1:CW], shadow[i]) : '0;
		assign term_b[i] = light_en[i] ?
			lmc_pkg::light_term(cfg.light_color[i][CW-1:0], shadow[i]) : '0;

		assign acc_r[i+1] = lmc_pkg::sat_add(acc_r[i], term_r[i]);
		assign acc_g[i+1] = lmc_pkg::sat_add(acc_g[i], term_g[i]);
		assign acc_b[i+1] = lmc_pkg::sat_add(acc_b[i], term_b[i]);
	end

	assign lit_red   = acc_r[MAX_LIGHTS];
	assign lit_green = acc_g[MAX_LIGHTS];
	assign lit_blue  = acc_b[MAX_LIGHTS];

endmodule

// ----- design/lightmap_lumel_combine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lightmap_lumel_combine
// lumel color combiner: static color plus ambient plus shadowed light colors
// ----------------------------------------------------------------------------
// usage
//   lumels enter on the lumel channel (lumel_valid / lumel_stall): static rgb,
//   one shadow byte per light and the last_lumel marker. one result per lumel
//   leaves on the lit channel (lit_valid / lit_stall) in arrival order, with
//   out_last copied from last_lumel.
//   ambient color, light count and light colors are set over the apb port
//   while no lumel is in flight; pready is always high.
// pipeline and throughput
//   an accepted transfer lands in the input register, and the result
//   register loads from it once the result stage is empty or its content
//   moves on; lit_valid rises when the result register loads. the combine
//   logic (up to twelve 10x8 multiplies and a five-deep chain of saturating
//   adds) sits between the two registers. one lumel per cycle sustained
//   while lit_stall is low.
// stall
//   a stalled result holds in the result register; a new lumel is still taken
//   into the input register while it is empty, and lumel_stall rises only
//   when both stages are full and lit_stall is high.
// reset
//   arst_n clears both stage valid bits and all configuration registers.
// ----------------------------------------------------------------------------
module lightmap_lumel_combine #(
	parameter int unsigned MAX_LIGHTS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lmc_pkg::ADDR_W-1:0]  paddr,
	input  logic [lmc_pkg::DATA_W-1:0]  pwdata,
	output logic [lmc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// lumel channel
	input  logic                        lumel_valid,
	output logic                        lumel_stall,
	input  logic [lmc_pkg::CHAN_W-1:0]  static_red,
	input  logic [lmc_pkg::CHAN_W-1:0]  static_green,
	input  logic [lmc_pkg::CHAN_W-1:0]  static_blue,
	input  logic [lmc_pkg::CHAN_W-1:0]  shadow_0,
	input  logic [lmc_pkg::CHAN_W-1:0]  shadow_1,
	input  logic [lmc_pkg::CHAN_W-1:0]  shadow_2,
	input  logic [lmc_pkg::CHAN_W-1:0]  shadow_3,
	input  logic                        last_lumel,
	// lit channel
	output logic                        lit_valid,
	input  logic                        lit_stall,
	output logic [lmc_pkg::CHAN_W-1:0]  lit_red,
	output logic [lmc_pkg::CHAN_W-1:0]  lit_green,
	output logic [lmc_pkg::CHAN_W-1:0]  lit_blue,
	output logic                        out_last
);

	localparam int unsigned CH = lmc_pkg::CHAN_W;

	lmc_pkg::lmc_cfg_t cfg;

	// stage 1: registered input
	logic                                   valid_s1;
	logic [CH-1:0]                          red_s1;
	logic [CH-1:0]                          green_s1;
	logic [CH-1:0]                          blue_s1;
	logic [lmc_pkg::NUM_LIGHT_SLOTS-1:0][CH-1:0] shadow_s1;
	logic                                   last_s1;

	// stage 2: registered result
	logic          valid_s2;
	logic [CH-1:0] red_s2;
	logic [CH-1:0] green_s2;
	logic [CH-1:0] blue_s2;
	logic          last_s2;

	logic          adv_s2;
	logic          adv_s1;
	logic          take;
	logic [CH-1:0] calc_red;
	logic [CH-1:0] calc_green;
	logic [CH-1:0] calc_blue;

	lmc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage enables: a stage loads when it is empty or its content moves on
	assign adv_s2      = !valid_s2 || !lit_stall;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign lumel_stall = !adv_s1;
	assign take        = lumel_valid && !lumel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= lumel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			red_s1       <= static_red;
			green_s1     <= static_green;
			blue_s1      <= static_blue;
			shadow_s1[0] <= shadow_0;
			shadow_s1[1] <= shadow_1;
			shadow_s1[2] <= shadow_2;
			shadow_s1[3] <= shadow_3;
			last_s1      <= last_lumel;
		end
	end

	lmc_shade_calc #(
		.MAX_LIGHTS (MAX_LIGHTS)
	) u_calc (
		.cfg          (cfg),
		.static_red   (red_s1),
		.static_green (green_s1),
		.static_blue  (blue_s1),
		.shadow       (shadow_s1[MAX_LIGHTS-1:0]),
		.lit_red      (calc_red),
		.lit_green    (calc_green),
		.lit_blue     (calc_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			red_s2   <= calc_red;
			green_s2 <= calc_green;
			blue_s2  <= calc_blue;
			last_s2  <= last_s1;
		end
	end

	assign lit_valid = valid_s2;
	assign lit_red   = red_s2;
	assign lit_green = green_s2;
	assign lit_blue  = blue_s2;
	assign out_last  = last_s2;

	// input side backs up only when both stages hold work and the output is stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		lumel_stall |-> (valid_s1 && valid_s2 && lit_stall))
		else $error("lumel_stall raised with room in the pipeline");

	// an accepted transfer occupies stage 1 on the next edge
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted lumel lost from stage 1");

	// a stage 1 item that cannot move stays put with its payload
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(red_s1) && $stable(last_s1)))
		else $error("stage 1 item dropped or changed while blocked");

	// a delivered result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !lit_stall && !valid_s1) |=> !lit_valid)
		else $error("result repeated after transfer");

endmodule
